FILE: rtl/kuz_pkg.sv
// Package with the Kuznyechik tables, the linear layer and shared types.
package kuz_pkg;

  localparam int NumRoundKeys = 10;
  localparam int NumFeistelSteps = 32;
  localparam int BlockW = 128;
  localparam int HalfW = 64;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 64;
  localparam int LinMatW = 16 * 16 * 8;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KEY_WORD_0 = 2'd0,
    KEY_WORD_1 = 2'd1,
    KEY_WORD_2 = 2'd2,
    KEY_WORD_3 = 2'd3
  } cfg_reg_e;

  localparam logic [7:0] SboxFwd [256] = '{
    8'hfc, 8'hee, 8'hdd, 8'h11, 8'hcf, 8'h6e, 8'h31, 8'h16,
    8'hfb, 8'hc4, 8'hfa, 8'hda, 8'h23, 8'hc5, 8'h04, 8'h4d,
    8'he9, 8'h77, 8'hf0, 8'hdb, 8'h93, 8'h2e, 8'h99, 8'hba,
    8'h17, 8'h36, 8'hf1, 8'hbb, 8'h14, 8'hcd, 8'h5f, 8'hc1,
    8'hf9, 8'h18, 8'h65, 8'h5a, 8'he2, 8'h5c, 8'hef, 8'h21,
    8'h81, 8'h1c, 8'h3c, 8'h42, 8'h8b, 8'h01, 8'h8e, 8'h4f,
    8'h05, 8'h84, 8'h02, 8'hae, 8'he3, 8'h6a, 8'h8f, 8'ha0,
    8'h06, 8'h0b, 8'hed, 8'h98, 8'h7f, 8'hd4, 8'hd3, 8'h1f,
    8'heb, 8'h34, 8'h2c, 8'h51, 8'hea, 8'hc8, 8'h48, 8'hab,
    8'hf2, 8'h2a, 8'h68, 8'ha2, 8'hfd, 8'h3a, 8'hce, 8'hcc,
    8'hb5, 8'h70, 8'h0e, 8'h56, 8'h08, 8'h0c, 8'h76, 8'h12,
    8'hbf, 8'h72, 8'h13, 8'h47, 8'h9c, 8'hb7, 8'h5d, 8'h87,
    8'h15, 8'ha1, 8'h96, 8'h29, 8'h10, 8'h7b, 8'h9a, 8'hc7,
    8'hf3, 8'h91, 8'h78, 8'h6f, 8'h9d, 8'h9e, 8'hb2, 8'hb1,
    8'h32, 8'h75, 8'h19, 8'h3d, 8'hff, 8'h35, 8'h8a, 8'h7e,
    8'h6d, 8'h54, 8'hc6, 8'h80, 8'hc3, 8'hbd, 8'h0d, 8'h57,
    8'hdf, 8'hf5, 8'h24, 8'ha9, 8'h3e, 8'ha8, 8'h43, 8'hc9,
    8'hd7, 8'h79, 8'hd6, 8'hf6, 8'h7c, 8'h22, 8'hb9, 8'h03,
    8'he0, 8'h0f, 8'hec, 8'hde, 8'h7a, 8'h94, 8'hb0, 8'hbc,
    8'hdc, 8'he8, 8'h28, 8'h50, 8'h4e, 8'h33, 8'h0a, 8'h4a,
    8'ha7, 8'h97, 8'h60, 8'h73, 8'h1e, 8'h00, 8'h62, 8'h44,
    8'h1a, 8'hb8, 8'h38, 8'h82, 8'h64, 8'h9f, 8'h26, 8'h41,
    8'had, 8'h45, 8'h46, 8'h92, 8'h27, 8'h5e, 8'h55, 8'h2f,
    8'h8c, 8'ha3, 8'ha5, 8'h7d, 8'h69, 8'hd5, 8'h95, 8'h3b,
    8'h07, 8'h58, 8'hb3, 8'h40, 8'h86, 8'hac, 8'h1d, 8'hf7,
    8'h30, 8'h37, 8'h6b, 8'he4, 8'h88, 8'hd9, 8'he7, 8'h89,
    8'he1, 8'h1b, 8'h83, 8'h49, 8'h4c, 8'h3f, 8'hf8, 8'hfe,
    8'h8d, 8'h53, 8'haa, 8'h90, 8'hca, 8'hd8, 8'h85, 8'h61,
    8'h20, 8'h71, 8'h67, 8'ha4, 8'h2d, 8'h2b, 8'h09, 8'h5b,
    8'hcb, 8'h9b, 8'h25, 8'hd0, 8'hbe, 8'he5, 8'h6c, 8'h52,
    8'h59, 8'ha6, 8'h74, 8'hd2, 8'he6, 8'hf4, 8'hb4, 8'hc0,
    8'hd1, 8'h66, 8'haf, 8'hc2, 8'h39, 8'h4b, 8'h63, 8'hb6
  };

  localparam logic [7:0] SboxInv [256] = '{
    8'ha5, 8'h2d, 8'h32, 8'h8f, 8'h0e, 8'h30, 8'h38, 8'hc0,
    8'h54, 8'he6, 8'h9e, 8'h39, 8'h55, 8'h7e, 8'h52, 8'h91,
    8'h64, 8'h03, 8'h57, 8'h5a, 8'h1c, 8'h60, 8'h07, 8'h18,
    8'h21, 8'h72, 8'ha8, 8'hd1, 8'h29, 8'hc6, 8'ha4, 8'h3f,
    8'he0, 8'h27, 8'h8d, 8'h0c, 8'h82, 8'hea, 8'hae, 8'hb4,
    8'h9a, 8'h63, 8'h49, 8'he5, 8'h42, 8'he4, 8'h15, 8'hb7,
    8'hc8, 8'h06, 8'h70, 8'h9d, 8'h41, 8'h75, 8'h19, 8'hc9,
    8'haa, 8'hfc, 8'h4d, 8'hbf, 8'h2a, 8'h73, 8'h84, 8'hd5,
    8'hc3, 8'haf, 8'h2b, 8'h86, 8'ha7, 8'hb1, 8'hb2, 8'h5b,
    8'h46, 8'hd3, 8'h9f, 8'hfd, 8'hd4, 8'h0f, 8'h9c, 8'h2f,
    8'h9b, 8'h43, 8'hef, 8'hd9, 8'h79, 8'hb6, 8'h53, 8'h7f,
    8'hc1, 8'hf0, 8'h23, 8'he7, 8'h25, 8'h5e, 8'hb5, 8'h1e,
    8'ha2, 8'hdf, 8'ha6, 8'hfe, 8'hac, 8'h22, 8'hf9, 8'he2,
    8'h4a, 8'hbc, 8'h35, 8'hca, 8'hee, 8'h78, 8'h05, 8'h6b,
    8'h51, 8'he1, 8'h59, 8'ha3, 8'hf2, 8'h71, 8'h56, 8'h11,
    8'h6a, 8'h89, 8'h94, 8'h65, 8'h8c, 8'hbb, 8'h77, 8'h3c,
    8'h7b, 8'h28, 8'hab, 8'hd2, 8'h31, 8'hde, 8'hc4, 8'h5f,
    8'hcc, 8'hcf, 8'h76, 8'h2c, 8'hb8, 8'hd8, 8'h2e, 8'h36,
    8'hdb, 8'h69, 8'hb3, 8'h14, 8'h95, 8'hbe, 8'h62, 8'ha1,
    8'h3b, 8'h16, 8'h66, 8'he9, 8'h5c, 8'h6c, 8'h6d, 8'had,
    8'h37, 8'h61, 8'h4b, 8'hb9, 8'he3, 8'hba, 8'hf1, 8'ha0,
    8'h85, 8'h83, 8'hda, 8'h47, 8'hc5, 8'hb0, 8'h33, 8'hfa,
    8'h96, 8'h6f, 8'h6e, 8'hc2, 8'hf6, 8'h50, 8'hff, 8'h5d,
    8'ha9, 8'h8e, 8'h17, 8'h1b, 8'h97, 8'h7d, 8'hec, 8'h58,
    8'hf7, 8'h1f, 8'hfb, 8'h7c, 8'h09, 8'h0d, 8'h7a, 8'h67,
    8'h45, 8'h87, 8'hdc, 8'he8, 8'h4f, 8'h1d, 8'h4e, 8'h04,
    8'heb, 8'hf8, 8'hf3, 8'h3e, 8'h3d, 8'hbd, 8'h8a, 8'h88,
    8'hdd, 8'hcd, 8'h0b, 8'h13, 8'h98, 8'h02, 8'h93, 8'h80,
    8'h90, 8'hd0, 8'h24, 8'h34, 8'hcb, 8'hed, 8'hf4, 8'hce,
    8'h99, 8'h10, 8'h44, 8'h40, 8'h92, 8'h3a, 8'h01, 8'h26,
    8'h12, 8'h1a, 8'h48, 8'h68, 8'hf5, 8'h81, 8'h8b, 8'hc7,
    8'hd6, 8'h20, 8'h0a, 8'h08, 8'h00, 8'h4c, 8'hd7, 8'h74
  };

  localparam logic [7:0] LinCoef [16] = '{
    8'd148, 8'd32, 8'd133, 8'd16, 8'd194, 8'd192, 8'd1, 8'd251,
    8'd1, 8'd192, 8'd194, 8'd16, 8'd133, 8'd32, 8'd148, 8'd1
  };

  // Multiply in GF(2^8) modulo x^8+x^7+x^6+x+1 (eight shift-and-add steps).
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] x;
    logic [7:0] acc;
    x = {1'b0, a};
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ x[7:0];
      x = {x[7:0], 1'b0};
      if (x[8]) x = x ^ 9'h1C3;
    end
    return acc;
  endfunction

  // One step of the linear feedback: weighted sum of the sixteen bytes.
  function automatic logic [7:0] lin_mix(input logic [BlockW-1:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 16; i++) begin
      acc = acc ^ gf_mul(LinCoef[i], b[BlockW-1-8*i -: 8]);
    end
    return acc;
  endfunction

  // Forward linear step R: byte 0 is the most significant byte.
  function automatic logic [BlockW-1:0] r_fwd(input logic [BlockW-1:0] b);
    return {lin_mix(b), b[BlockW-1:8]};
  endfunction

  // Inverse linear step: rotate left by one byte, then remix the last byte.
  function automatic logic [BlockW-1:0] r_inv(input logic [BlockW-1:0] b);
    logic [BlockW-1:0] t;
    t = {b[BlockW-9:0], b[BlockW-1 -: 8]};
    return {t[BlockW-1:8], lin_mix(t)};
  endfunction

  // Sixteen R steps in a row; used only to build the constants below.
  function automatic logic [BlockW-1:0] r16(input logic [BlockW-1:0] b,
                                            input logic inverse);
    logic [BlockW-1:0] v;
    v = b;
    for (int i = 0; i < 16; i++) v = inverse ? r_inv(v) : r_fwd(v);
    return v;
  endfunction

  // Byte matrix of the whole linear layer: entry (i, j) sits at 8*(16*i+j).
  function automatic logic [LinMatW-1:0] lin_matrix(input logic inverse);
    logic [LinMatW-1:0] m;
    logic [BlockW-1:0] col;
    m = '0;
    for (int j = 0; j < 16; j++) begin
      col = '0;
      col[BlockW-8-8*j] = 1'b1;
      col = r16(col, inverse);
      for (int i = 0; i < 16; i++) m[8*(16*i+j) +: 8] = col[BlockW-1-8*i -: 8];
    end
    return m;
  endfunction

  // Key schedule constants C_i = L(i) for i = 1..32, C_1 in the low slot.
  function automatic logic [NumFeistelSteps*BlockW-1:0] round_consts();
    logic [NumFeistelSteps*BlockW-1:0] c;
    c = '0;
    for (int i = 0; i < NumFeistelSteps; i++) begin
      c[BlockW*i +: BlockW] = r16(BlockW'(i + 1), 1'b0);
    end
    return c;
  endfunction

  localparam logic [LinMatW-1:0] LinFwdMat = lin_matrix(1'b0);
  localparam logic [LinMatW-1:0] LinInvMat = lin_matrix(1'b1);
  localparam logic [NumFeistelSteps*BlockW-1:0] RoundConst = round_consts();

  // Full linear layer as a flat product with a constant byte matrix.
  function automatic logic [BlockW-1:0] lin_apply(input logic [LinMatW-1:0] m,
                                                  input logic [BlockW-1:0] b);
    logic [BlockW-1:0] r;
    logic [7:0] acc;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      acc = '0;
      for (int j = 0; j < 16; j++) begin
        acc = acc ^ gf_mul(m[8*(16*i+j) +: 8], b[BlockW-1-8*j -: 8]);
      end
      r[BlockW-1-8*i -: 8] = acc;
    end
    return r;
  endfunction

  function automatic logic [BlockW-1:0] lin_fwd(input logic [BlockW-1:0] b);
    return lin_apply(LinFwdMat, b);
  endfunction

  function automatic logic [BlockW-1:0] lin_inv(input logic [BlockW-1:0] b);
    return lin_apply(LinInvMat, b);
  endfunction

  function automatic logic [BlockW-1:0] sub_fwd(input logic [BlockW-1:0] b);
    logic [BlockW-1:0] r;
    for (int i = 0; i < 16; i++) r[8*i +: 8] = SboxFwd[b[8*i +: 8]];
    return r;
  endfunction

  function automatic logic [BlockW-1:0] sub_inv(input logic [BlockW-1:0] b);
    logic [BlockW-1:0] r;
    for (int i = 0; i < 16; i++) r[8*i +: 8] = SboxInv[b[8*i +: 8]];
    return r;
  endfunction

endpackage

FILE: rtl/kuz_if.sv
// Valid/ready channel interfaces for requests and results.
interface kuz_req_if;
  import kuz_pkg::*;
  logic valid;
  logic ready;
  logic operation;
  logic [HalfW-1:0] block_hi;
  logic [HalfW-1:0] block_lo;
  modport source (output valid, operation, block_hi, block_lo, input ready);
  modport sink (input valid, operation, block_hi, block_lo, output ready);
endinterface

interface kuz_rsp_if;
  import kuz_pkg::*;
  logic valid;
  logic ready;
  logic [HalfW-1:0] result_hi;
  logic [HalfW-1:0] result_lo;
  modport source (output valid, result_hi, result_lo, input ready);
  modport sink (input valid, result_hi, result_lo, output ready);
endinterface

FILE: rtl/kuznyechik_block_cipher.sv
// Kuznyechik (GOST R 34.12-2015) block cipher core with a ten-stage round pipeline.
// Each request encrypts or decrypts one 128-bit block under the 256-bit key held in four
// key words. The datapath is a pipeline of ten register stages, one cipher round per stage,
// so a new request can enter in every cycle while the round keys are ready and the output
// is not stalled. When the result at the output is not taken, the whole pipeline holds and
// the request side is stalled. After reset and after any key word write the core expands
// the ten round keys, one Feistel step per cycle: the key words are loaded first and the 32
// steps follow, so requests are held off until the last step after the last write is done.
// Key words must only be written while no request is in flight.
module kuznyechik_block_cipher
  import kuz_pkg::*;
#(
  parameter int NUM_ROUND_KEYS = NumRoundKeys
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  kuz_req_if.sink             req,
  kuz_rsp_if.source           rsp
);

  localparam int StepCntW = 6;
  localparam int CnstIdxW = $clog2(NumFeistelSteps);
  localparam logic [StepCntW-1:0] LastStep = StepCntW'(NumFeistelSteps);

  logic [CfgDataW-1:0] key_word_q [4];
  logic [BlockW-1:0] rk_q [NUM_ROUND_KEYS];
  logic keys_ready_q;
  logic [StepCntW-1:0] exp_step_q;
  logic [BlockW-1:0] exp_left_q, exp_right_q;
  logic [BlockW-1:0] key_left, key_right;
  logic [CnstIdxW-1:0] cnst_idx;
  logic [BlockW-1:0] feistel_t;
  logic exp_run;

  logic [NUM_ROUND_KEYS-1:0] vld_q;
  logic [NUM_ROUND_KEYS-1:0] op_q;
  logic [BlockW-1:0] data_q [NUM_ROUND_KEYS];
  logic [BlockW-1:0] data_d [NUM_ROUND_KEYS];
  logic adv;
  logic req_fire;

  // Handshakes: the pipeline moves whenever the output stage is free or drained.
  assign adv = !vld_q[NUM_ROUND_KEYS-1] || rsp.ready;
  assign req.ready = adv && keys_ready_q && !cfg_we_i;
  assign req_fire = req.valid && req.ready;
  assign rsp.valid = vld_q[NUM_ROUND_KEYS-1];
  assign rsp.result_hi = data_q[NUM_ROUND_KEYS-1][BlockW-1:HalfW];
  assign rsp.result_lo = data_q[NUM_ROUND_KEYS-1][HalfW-1:0];

  // Key word registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_word_q[i] <= '0;
    end else if (cfg_we_i) begin
      key_word_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // One Feistel step of the key schedule per cycle.
  assign exp_run = !keys_ready_q && !cfg_we_i;
  assign key_left = {key_word_q[KEY_WORD_0], key_word_q[KEY_WORD_1]};
  assign key_right = {key_word_q[KEY_WORD_2], key_word_q[KEY_WORD_3]};
  assign cnst_idx = CnstIdxW'(exp_step_q - StepCntW'(1));
  assign feistel_t = lin_fwd(sub_fwd(exp_left_q ^ RoundConst[BlockW*cnst_idx +: BlockW]))
                     ^ exp_right_q;

  // Expansion control: a key write restarts it, the last step marks the keys ready.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keys_ready_q <= 1'b0;
      exp_step_q <= '0;
    end else if (cfg_we_i) begin
      keys_ready_q <= 1'b0;
      exp_step_q <= '0;
    end else if (!keys_ready_q) begin
      if (exp_step_q == LastStep) keys_ready_q <= 1'b1;
      else exp_step_q <= exp_step_q + StepCntW'(1);
    end
  end

  // Feistel halves and round keys; every eighth step stores a pair of keys.
  always_ff @(posedge clk_i) begin
    if (exp_run) begin
      if (exp_step_q == '0) begin
        exp_left_q <= key_left;
        exp_right_q <= key_right;
        rk_q[0] <= key_left;
        rk_q[1] <= key_right;
      end else begin
        exp_left_q <= feistel_t;
        exp_right_q <= exp_left_q;
        if (exp_step_q[2:0] == 3'd0) begin
          rk_q[{exp_step_q[StepCntW-1:3], 1'b0}] <= feistel_t;
          rk_q[{exp_step_q[StepCntW-1:3], 1'b1}] <= exp_left_q;
        end
      end
    end
  end

  // Round stages. Encryption: key XOR, S-box and L in stages 0..8, the last key XOR in
  // stage 9. Decryption: inverse L, inverse S-box and key XOR in stages 0..8 (stage 0 first
  // removes the last round key), stage 9 passes the block through.
  for (genvar g = 0; g < NUM_ROUND_KEYS; g++) begin : g_stage
    logic [BlockW-1:0] src;
    logic src_op;
    logic [BlockW-1:0] enc_res;
    logic [BlockW-1:0] dec_res;
    if (g == 0) begin : g_in
      assign src = {req.block_hi, req.block_lo};
      assign src_op = req.operation;
    end else begin : g_mid
      assign src = data_q[g-1];
      assign src_op = op_q[g-1];
    end
    if (g < NUM_ROUND_KEYS - 1) begin : g_enc_round
      assign enc_res = lin_fwd(sub_fwd(src ^ rk_q[g]));
    end else begin : g_enc_last
      assign enc_res = src ^ rk_q[g];
    end
    if (g == 0) begin : g_dec_first
      assign dec_res = sub_inv(lin_inv(src ^ rk_q[NUM_ROUND_KEYS-1]))
                       ^ rk_q[NUM_ROUND_KEYS-2];
    end else if (g < NUM_ROUND_KEYS - 1) begin : g_dec_round
      assign dec_res = sub_inv(lin_inv(src)) ^ rk_q[NUM_ROUND_KEYS-2-g];
    end else begin : g_dec_last
      assign dec_res = src;
    end
    assign data_d[g] = (src_op == OP_DECRYPT) ? dec_res : enc_res;
  end

  // Valid and operation bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      op_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NUM_ROUND_KEYS-2:0], req_fire};
      op_q <= {op_q[NUM_ROUND_KEYS-2:0], req.operation};
    end
  end

  // Stage data registers.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int s = 0; s < NUM_ROUND_KEYS; s++) data_q[s] <= data_d[s];
    end
  end

  // A pending result holds while the sink stalls.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(data_q[NUM_ROUND_KEYS-1]))
    else $error("stalled result changed");
  // No request is taken while the round keys are being expanded.
  a_keys_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |-> keys_ready_q)
    else $error("request accepted with stale round keys");
  // A stalled output blocks the request side.
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |-> !req.ready)
    else $error("request accepted while the pipeline is stalled");
  // The expansion counter never runs past the last Feistel step.
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_step_q <= LastStep)
    else $error("key schedule step out of range");

endmodule
